>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CKC_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// plain expression that must be true at every clock edge outside reset
`define CKC_ASSERT_ALWAYS(label, expr, msg) \
  `CKC_ASSERT_PROP(label, (expr), msg)

`endif

>>> rtl/core/ckc_pkg.sv
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types, constants and the case fold for the keyword counter
// ----------------------------------------------------------------------------
`default_nettype none

package ckc_pkg;

  // default and largest keyword length
  localparam int unsigned MAX_KEYWORD_DEFAULT = 16;
  localparam int unsigned KEY_CHARS           = 16;

  // field widths
  localparam int unsigned LINE_W  = 24;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned KLEN_W  = 5;
  localparam int unsigned ADDR_W  = 5;

  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [COL_W-1:0]   COL_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] UPPER_FIRST  = 8'h41;
  localparam logic [7:0] UPPER_LAST   = 8'h5A;
  localparam logic [7:0] CASE_GAP     = 8'd32;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_t;

  // record kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // one result item
  typedef struct packed {
    logic               kind;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    logic [COUNT_W-1:0] count;
    logic               fin;
  } rec_t;

  // ascii upper case letters map to lower case, all else unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_FIRST && b <= UPPER_LAST) r = b + CASE_GAP;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/caseless_keyword_counter_core.sv
// ----------------------------------------------------------------------------
// caseless_keyword_counter_core
// Case-insensitive keyword search over a byte stream with per-match records
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata text_byte, tlast end_of_text
//  m_*       out  m_tvalid/m_tready  tdata line/col/count, tuser kind, tlast final
//  apb       in   psel/penable       paddr, pwdata, prdata, pready always high
//
//  one text byte is taken per cycle while s_tready is high; the window compare,
//  counters and record build finish in the cycle of acceptance and land in a
//  four-entry result queue; a byte gives at most two items (match and summary);
//  s_tready is high while the queue holds two items or fewer, so output stalls
//  reach the input only once three items wait
//  rst is synchronous and clears counters, queue and registers; no clear pass
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module caseless_keyword_counter_core
  import ckc_pkg::*;
#(
  parameter int unsigned MAX_KEYWORD = MAX_KEYWORD_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [7:0] text_byte
  input  wire logic                s_tlast,   // end_of_text
  // output stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [63:0]              m_tdata,   // [23:0] line_number, [39:24] start_column,
                                              // [63:40] occurrence_count
  output logic                     m_tuser,   // [0] record_kind
  output logic                     m_tlast,   // final_record
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [CFG_W-1:0]    pwdata,
  output logic [CFG_W-1:0]         prdata,
  output logic                     pready
);

  localparam int unsigned LW      = $clog2(MAX_KEYWORD + 1);
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // configuration registers
  logic [CFG_W-1:0]  key_low;
  logic [CFG_W-1:0]  key_high;
  logic [KLEN_W-1:0] key_len_reg;

  // stream state
  logic [7:0]         window [MAX_KEYWORD];
  logic [LW-1:0]      window_fill;
  logic [LINE_W-1:0]  line_counter;
  logic [COL_W-1:0]   column_counter;
  logic [COUNT_W-1:0] match_counter;

  // result queue
  rec_t               queue [QDEPTH];
  logic [QPTR_W-1:0]  q_head;
  logic [QPTR_W-1:0]  q_tail;
  logic [QCNT_W-1:0]  q_count;

  logic s_fire;
  logic m_fire;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = reg_idx_t'(paddr[4:3]);
  assign s_tready = (q_count <= QCNT_W'(QDEPTH - 2));
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (q_count != '0);
  assign m_fire   = m_tvalid && m_tready;

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_KEY_LOW:  prdata = key_low;
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LEN:  prdata = {{(CFG_W-KLEN_W){1'b0}}, key_len_reg};
      default:      prdata = '0;
    endcase
  end

  // effective keyword length, clamped to 1..MAX_KEYWORD
  logic [LW-1:0] key_len;
  always_comb begin
    if (key_len_reg == '0) begin
      key_len = LW'(1);
    end else if (key_len_reg > KLEN_W'(MAX_KEYWORD)) begin
      key_len = LW'(MAX_KEYWORD);
    end else begin
      key_len = LW'(key_len_reg);
    end
  end

  // folded keyword characters
  logic [7:0] key_char [KEY_CHARS];
  always_comb begin
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (i < 8) key_char[i] = fold_case(key_low[i*8 +: 8]);
      else       key_char[i] = fold_case(key_high[(i-8)*8 +: 8]);
    end
  end

  // window after this byte shifts in
  logic [7:0] window_next [MAX_KEYWORD];
  always_comb begin
    window_next[0] = fold_case(s_tdata);
    for (int j = 1; j < MAX_KEYWORD; j++) window_next[j] = window[j-1];
  end

  // parallel compare: window entry j against keyword char len-1-j
  logic [MAX_KEYWORD-1:0] lane_ok;
  always_comb begin
    logic [KLEN_W-1:0] kidx;
    for (int j = 0; j < MAX_KEYWORD; j++) begin
      kidx = KLEN_W'(key_len) - KLEN_W'(j) - KLEN_W'(1);
      if (LW'(j) < key_len) begin
        lane_ok[j] = (window_next[j] == key_char[kidx[3:0]]);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  // next stream state and records
  logic               is_newline;
  logic [LW-1:0]      fill_next;
  logic [LINE_W-1:0]  line_next;
  logic [COL_W-1:0]   col_next;
  logic [COUNT_W-1:0] match_next;
  logic               hit;
  rec_t               rec_match;
  rec_t               rec_sum;

  always_comb begin
    is_newline = (s_tdata == NEWLINE_BYTE);
    fill_next  = window_fill;
    line_next  = line_counter;
    col_next   = column_counter;
    hit        = 1'b0;
    if (is_newline) begin
      fill_next = '0;
      if (line_counter != LINE_MAX) line_next = line_counter + LINE_W'(1);
      col_next  = '0;
    end else begin
      if (window_fill != LW'(MAX_KEYWORD)) fill_next = window_fill + LW'(1);
      if (column_counter != COL_MAX) col_next = column_counter + COL_W'(1);
      hit = (fill_next >= key_len) && (&lane_ok);
    end
    match_next = match_counter;
    if (hit && match_counter != COUNT_MAX) match_next = match_counter + COUNT_W'(1);

    rec_match.kind  = KIND_MATCH;
    rec_match.line  = line_counter;
    rec_match.col   = column_counter - COL_W'(key_len) + COL_W'(1);
    rec_match.count = match_next;
    rec_match.fin   = !s_tlast;

    rec_sum.kind  = KIND_SUMMARY;
    rec_sum.line  = line_next;
    rec_sum.col   = '0;
    rec_sum.count = match_next;
    rec_sum.fin   = 1'b1;
  end

  // queue push: first slot is the match if any, summary otherwise
  logic [1:0] push_n;
  rec_t       push_a;
  assign push_n = s_fire ? (2'(hit) + 2'(s_tlast)) : 2'd0;
  assign push_a = hit ? rec_match : rec_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      key_len_reg <= KLEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEY_LOW:  key_low     <= pwdata;
        REG_KEY_HIGH: key_high    <= pwdata;
        REG_KEY_LEN:  key_len_reg <= pwdata[KLEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // window taps, payload only
  always_ff @(posedge clk) begin
    if (s_fire && !is_newline) begin
      for (int j = 0; j < MAX_KEYWORD; j++) window[j] <= window_next[j];
    end
  end

  // stream counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill    <= '0;
      line_counter   <= LINE_W'(1);
      column_counter <= '0;
      match_counter  <= '0;
    end else if (s_fire) begin
      if (s_tlast) begin
        window_fill    <= '0;
        line_counter   <= LINE_W'(1);
        column_counter <= '0;
        match_counter  <= '0;
      end else begin
        window_fill    <= fill_next;
        line_counter   <= line_next;
        column_counter <= col_next;
        match_counter  <= match_next;
      end
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[q_tail] <= push_a;
    if (push_n == 2'd2) queue[q_tail + QPTR_W'(1)] <= rec_sum;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      if (m_fire) q_head <= q_head + QPTR_W'(1);
      q_tail  <= q_tail + QPTR_W'(push_n);
      q_count <= q_count + QCNT_W'(push_n) - QCNT_W'(m_fire);
    end
  end

  // output drive
  rec_t head_rec;
  assign head_rec = queue[q_head];
  assign m_tdata  = {head_rec.count, head_rec.col, head_rec.line};
  assign m_tuser  = head_rec.kind;
  assign m_tlast  = head_rec.fin;

  // check helpers
  logic eot_fire;
  logic nl_fire;
  logic text_idle;
  logic line_start;
  assign eot_fire   = s_fire && s_tlast;
  assign nl_fire    = s_fire && !s_tlast && is_newline;
  assign line_start = (column_counter == '0) && (window_fill == '0);
  assign text_idle  = line_start && (line_counter == LINE_W'(1)) && (match_counter == '0);

  // checks
  `CKC_ASSERT_ALWAYS(a_queue_bound, q_count <= QCNT_W'(QDEPTH), "result queue overflow")
  `CKC_ASSERT_PROP(a_eot_clears, eot_fire |=> text_idle, "stream state kept after end of text")
  `CKC_ASSERT_PROP(a_newline_col, nl_fire |=> line_start, "newline did not reset column and window")
  `CKC_ASSERT_PROP(a_newline_quiet, nl_fire |=> q_count <= $past(q_count), "newline produced an item")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for caseless_keyword_counter_core
//
// Text items go in on the s_* stream and match / summary records come back on
// m_*. A scoreboard predicts every record from the accepted bytes and the
// keyword registers and compares each returned record field by field. The
// keyword is set over APB once no records are pending, and read back. A short
// directed part covers case folding, short and clamped lengths, overlaps and
// newlines. Random phases then mix keyword copies, partial copies, overlapping
// letters, noise and newlines, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ckc_pkg::*;

  // expected record store and text model for the keyword search
  class keyword_scoreboard;
    logic [CFG_W-1:0]   key_low;
    logic [CFG_W-1:0]   key_high;
    logic [KLEN_W-1:0]  key_len_reg;
    logic [7:0]         recent[KEY_CHARS];
    int unsigned        recent_fill;
    logic [LINE_W-1:0]  line_no;
    logic [COL_W-1:0]   col_no;
    logic [COUNT_W-1:0] hit_total;
    rec_t               pending_records[$];
    int                 errors;
    int                 match_recs;
    int                 summaries;
    int                 bytes_in;

    function new();
      key_low     = '0;
      key_high    = '0;
      key_len_reg = KLEN_W'(1);
      errors      = 0;
      match_recs  = 0;
      summaries   = 0;
      bytes_in    = 0;
      restart_text();
    endfunction

    function void restart_text();
      foreach (recent[i]) recent[i] = 8'h00;
      recent_fill = 0;
      line_no     = LINE_W'(1);
      col_no      = '0;
      hit_total   = '0;
    endfunction

    function logic [7:0] to_lower(logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
    endfunction

    function logic [7:0] key_at(int unsigned i);
      return to_lower(i < 8 ? key_low[i*8 +: 8] : key_high[(i-8)*8 +: 8]);
    endfunction

    // zero length acts as one, anything past the window as the window
    function int unsigned span();
      if (key_len_reg == 0) return 1;
      if (key_len_reg > KEY_CHARS) return KEY_CHARS;
      return key_len_reg;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // one accepted text item: update the line state and queue its records
    function void note_byte(logic [7:0] b, logic eot);
      int unsigned        n;
      int                 i;
      logic [COL_W-1:0]   start;
      logic               hit;
      rec_t               r;
      bytes_in++;
      if (b == NEWLINE_BYTE) begin
        foreach (recent[k]) recent[k] = 8'h00;
        recent_fill = 0;
        if (line_no != LINE_MAX) line_no++;
        col_no = '0;
      end else begin
        n     = span();
        start = col_no - COL_W'(n - 1);
        for (i = KEY_CHARS - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = to_lower(b);
        if (recent_fill < KEY_CHARS) recent_fill++;
        if (col_no != COL_MAX) col_no++;
        hit = (recent_fill >= n);
        for (i = 0; i < n; i++)
          if (recent[n-1-i] != key_at(i)) hit = 1'b0;
        if (hit) begin
          if (hit_total != COUNT_MAX) hit_total++;
          r.kind  = KIND_MATCH;
          r.line  = line_no;
          r.col   = start;
          r.count = hit_total;
          r.fin   = !eot;
          pending_records.push_back(r);
        end
      end
      if (eot) begin
        r.kind  = KIND_SUMMARY;
        r.line  = line_no;
        r.col   = '0;
        r.count = hit_total;
        r.fin   = 1'b1;
        pending_records.push_back(r);
        restart_text();
      end
    endfunction

    // one returned record against the oldest expectation
    task check_record(rec_t got);
      rec_t want;
      if (pending_records.size() == 0) begin
        report($sformatf("record with none expected: kind %0d line %0d col %0d count %0d",
                         got.kind, got.line, got.col, got.count));
        return;
      end
      want = pending_records.pop_front();
      if (got.kind != want.kind)
        report($sformatf("record_kind %0d, expected %0d", got.kind, want.kind));
      if (got.line != want.line)
        report($sformatf("line_number %0d, expected %0d", got.line, want.line));
      if (got.col != want.col)
        report($sformatf("start_column %0d, expected %0d", got.col, want.col));
      if (got.count != want.count)
        report($sformatf("occurrence_count %0d, expected %0d", got.count, want.count));
      if (got.fin != want.fin)
        report($sformatf("final_record %0d, expected %0d", got.fin, want.fin));
      if (want.kind == KIND_SUMMARY) summaries++;
      else match_recs++;
    endtask
  endclass

  // clock, reset and block ports
  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = 8'h00;   // [7:0] text_byte
  logic               s_tlast  = 1'b0;    // end_of_text
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [63:0]        m_tdata;            // [23:0] line, [39:24] column, [63:40] count
  logic               m_tuser;            // [0] record_kind
  logic               m_tlast;            // final_record
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [ADDR_W-1:0]  paddr    = '0;
  logic [CFG_W-1:0]   pwdata   = '0;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  keyword_scoreboard  sb = new();

  // current keyword as the stimulus sees it
  logic [7:0]         kw_bytes[KEY_CHARS];
  int unsigned        kw_span;
  int                 settings_used = 0;
  bit                 calm = 1'b0;
  int unsigned        sink_hold = 0;

  caseless_keyword_counter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle lengths: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      sink_hold <= idle_len() - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // returned records
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_record(rec_t'({m_tuser, m_tdata[23:0], m_tdata[39:24], m_tdata[63:40],
                              m_tlast}));
  end

  // one text item, with an optional idle gap in front
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, eot);
  endtask

  task automatic send_text(input string s, input logic eot_at_end);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], eot_at_end && (i == s.len() - 1));
  endtask

  // hold the sender until every record is back and the block is quiet
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t r, input logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input reg_idx_t r, output logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    v = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write, mirror update and read back
  task automatic write_checked(input reg_idx_t r, input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] back;
    apb_write(r, v);
    case (r)
      REG_KEY_LOW:  sb.key_low = v;
      REG_KEY_HIGH: sb.key_high = v;
      REG_KEY_LEN:  sb.key_len_reg = v[KLEN_W-1:0];
      default: ;
    endcase
    apb_read(r, back);
    if (back !== v) sb.report($sformatf("register %s read back %h, wrote %h", r.name(), back, v));
  endtask

  task automatic set_keyword(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [KLEN_W-1:0] len);
    int i;
    for (i = 0; i < 8; i++) begin
      kw_bytes[i]   = lo[i*8 +: 8];
      kw_bytes[i+8] = hi[i*8 +: 8];
    end
    kw_span = (len == 0) ? 1 : (len > KEY_CHARS) ? KEY_CHARS : len;
    write_checked(REG_KEY_LOW, lo);
    write_checked(REG_KEY_HIGH, hi);
    write_checked(REG_KEY_LEN, CFG_W'(len));
    settings_used++;
  endtask

  // bytes next to the letter ranges, where a sloppy fold goes wrong
  function automatic logic [7:0] border_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h40;
      1:       return 8'h5B;
      2:       return 8'h60;
      3:       return 8'h7B;
      4:       return 8'h5A;
      default: return 8'h7A;
    endcase
  endfunction

  function automatic logic [7:0] key_byte_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + $urandom_range(0, 1));
    if (r < 70) return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + $urandom_range(0, 25));
    if (r < 80) return border_byte();
    if (r < 97) return 8'($urandom_range(0, 255));
    return NEWLINE_BYTE;
  endfunction

  function automatic logic [KLEN_W-1:0] len_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return KLEN_W'($urandom_range(1, 3));
    if (r < 75) return KLEN_W'($urandom_range(4, 16));
    if (r < 85) return '0;
    if (r < 93) return KLEN_W'($urandom_range(17, 31));
    return KLEN_W'(KEY_CHARS);
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] b);
    if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(0, 1))
      return b ^ 8'h20;
    return b;
  endfunction

  task automatic random_keyword(input logic [KLEN_W-1:0] len);
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    int i;
    for (i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = key_byte_pick();
      hi[i*8 +: 8] = key_byte_pick();
    end
    set_keyword(lo, hi, len);
  endtask

  // text built mostly from keyword copies in mixed case, with noise around them
  task automatic random_text(input int unsigned count);
    logic [7:0]  seg[$];
    int unsigned sent;
    int unsigned r;
    int unsigned stop;
    int          i;
    sent = 0;
    while (sent < count) begin
      seg.delete();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        stop = kw_span;
        if ($urandom_range(0, 5) == 0) stop = $urandom_range(1, kw_span);
        for (i = 0; i < stop; i++) seg.push_back(vary_case(kw_bytes[i]));
      end else if (r < 62) begin
        repeat ($urandom_range(1, 6)) seg.push_back(vary_case(8'(8'h61 + $urandom_range(0, 1))));
      end else if (r < 80) begin
        repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom_range(0, 255)));
      end else if (r < 88) begin
        seg.push_back(border_byte());
      end else if (r < 96) begin
        seg.push_back(NEWLINE_BYTE);
      end else if (r < 98) begin
        drain_results();
      end
      foreach (seg[k]) send_byte(seg[k], $urandom_range(0, 39) == 0);
      sent += seg.size();
    end
  endtask

  // run limit, far above the slowest correct run
  initial begin
    #24000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int ph;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset keyword is a single zero byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0);
    send_byte(8'h00, 1'b1);

    // folding stops at the letter ranges
    drain_results();
    set_keyword(64'h0000_0000_005B_7A41, '1, KLEN_W'(3));
    send_text("aZ[AZ{az\n[AZ[", 1'b1);

    // zero length acts as one character
    drain_results();
    set_keyword(64'h71, '0, '0);
    send_text("Qq", 1'b1);

    // overlapping matches
    drain_results();
    set_keyword(64'h61_6161, '0, KLEN_W'(3));
    send_text("AaAa", 1'b1);

    // two-character keyword on both sides of a newline
    drain_results();
    set_keyword(64'h5978, '0, KLEN_W'(2));
    send_text("..Xy\nxY", 1'b1);

    // random phases, every fourth one without idle cycles
    for (ph = 0; ph < 12; ph++) begin
      drain_results();
      calm = (ph % 4 == 3);
      case (ph)
        0:       set_keyword('1, '1, '1);
        1:       set_keyword('0, '0, KLEN_W'(KEY_CHARS));
        2:       random_keyword(KLEN_W'(1));
        default: random_keyword(len_pick());
      endcase
      random_text(125);
    end

    drain_results();
    repeat (6) @(posedge clk);
    $display("Run covered %0d text bytes under %0d keyword settings", sb.bytes_in,
             settings_used);
    $display("Checked %0d match records and %0d end-of-text summaries", sb.match_recs,
             sb.summaries);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
